// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file spc_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define SPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SPC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared kind codes, control struct and sizing constants for the shape pair
// collision test pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spc_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int PIPE_STAGES    = 4;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_POINT  = 2'd0;
  localparam kind_t KIND_RECT   = 2'd1;
  localparam kind_t KIND_CIRCLE = 2'd2;
  localparam kind_t KIND_BAD    = 2'd3;

  // use_dist: answer comes from the distance compare; otherwise hit is final
  typedef struct packed {
    logic use_dist;
    logic hit;
  } spc_ctrl_t;

endpackage

// ===== src/shape_pair_collision_test.sv =====
// ----------------------------------------------------------------------------
// shape_pair_collision_test
// Strict overlap test of two shapes (point, axis-aligned rectangle, circle)
// in signed fixed-point world coordinates, four-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                | per transfer
//  ---------+--------------------------------------+---------------------------
//  input    | in_valid / in_stall, in_first_*,     | one shape pair
//           | in_second_*                          |
//  result   | out_valid / out_stall, out_overlap   | one overlap flag
//
//  One pair per cycle is sustained while out_stall is low. Depth is set by
//  the prep, difference, multiply and compare stages. Each stage holds a
//  valid bit and loads when its downstream neighbor is empty or moving, so
//  bubbles collapse under stall and in_stall rises only when all four stages
//  hold an item and out_stall is high. Synchronous active-low reset clears
//  the valid bits only.
//
`timescale 1ns / 1ps

module shape_pair_collision_test #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_first_kind,
  input  logic signed [COORD_BITS-1:0] in_first_p0,
  input  logic signed [COORD_BITS-1:0] in_first_p1,
  input  logic signed [COORD_BITS-1:0] in_first_p2,
  input  logic signed [COORD_BITS-1:0] in_first_p3,
  input  logic [1:0]                   in_second_kind,
  input  logic signed [COORD_BITS-1:0] in_second_p0,
  input  logic signed [COORD_BITS-1:0] in_second_p1,
  input  logic signed [COORD_BITS-1:0] in_second_p2,
  input  logic signed [COORD_BITS-1:0] in_second_p3,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_overlap
);
  import spc_pkg::*;

  // stage valid bits
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  // stage load enables: a stage moves when empty or when its successor moves
  logic s1_adv, s2_adv, s3_adv, s4_adv;

  spc_ctrl_t                    s1_ctrl, s2_ctrl, s3_ctrl;
  logic signed [COORD_BITS-1:0] s1_ux, s1_vx, s1_uy, s1_vy, s1_ra, s1_rb;
  logic signed [COORD_BITS:0]   s2_dx, s2_dy, s2_rad;
  logic [2*COORD_BITS:0]        s3_sqx, s3_sqy, s3_sqr;

  assign s4_adv = !s4_valid_r || !out_stall;
  assign s3_adv = !s3_valid_r || s4_adv;
  assign s2_adv = !s2_valid_r || s3_adv;
  assign s1_adv = !s1_valid_r || s2_adv;

  // hold the input only when the whole pipe is full and the output is held
  assign in_stall  = !s1_adv;
  assign out_valid = s4_valid_r;

  // advance valid bits alongside the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= in_valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
      if (s3_adv) s3_valid_r <= s2_valid_r;
      if (s4_adv) s4_valid_r <= s3_valid_r;
    end
  end

  // stage 1: sort by kind, direct tests, pick distance operands
  spc_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk         (clk),
    .load        (s1_adv && in_valid),
    .first_kind  (in_first_kind),
    .first_p0    (in_first_p0),
    .first_p1    (in_first_p1),
    .first_p2    (in_first_p2),
    .first_p3    (in_first_p3),
    .second_kind (in_second_kind),
    .second_p0   (in_second_p0),
    .second_p1   (in_second_p1),
    .second_p2   (in_second_p2),
    .second_p3   (in_second_p3),
    .ctrl_r      (s1_ctrl),
    .ux_r        (s1_ux),
    .vx_r        (s1_vx),
    .uy_r        (s1_uy),
    .vy_r        (s1_vy),
    .ra_r        (s1_ra),
    .rb_r        (s1_rb)
  );

  // stage 2: offsets and radius sum
  spc_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk    (clk),
    .load   (s2_adv && s1_valid_r),
    .ctrl   (s1_ctrl),
    .ux     (s1_ux),
    .vx     (s1_vx),
    .uy     (s1_uy),
    .vy     (s1_vy),
    .ra     (s1_ra),
    .rb     (s1_rb),
    .ctrl_r (s2_ctrl),
    .dx_r   (s2_dx),
    .dy_r   (s2_dy),
    .rad_r  (s2_rad)
  );

  // stage 3: exact squares
  spc_square #(.COORD_BITS(COORD_BITS)) u_square (
    .clk    (clk),
    .load   (s3_adv && s2_valid_r),
    .ctrl   (s2_ctrl),
    .dx     (s2_dx),
    .dy     (s2_dy),
    .rad    (s2_rad),
    .ctrl_r (s3_ctrl),
    .sqx_r  (s3_sqx),
    .sqy_r  (s3_sqy),
    .sqr_r  (s3_sqr)
  );

  // stage 4: sum, strict compare, final select into the output register
  spc_compare #(.COORD_BITS(COORD_BITS)) u_compare (
    .clk       (clk),
    .load      (s4_adv && s3_valid_r),
    .ctrl      (s3_ctrl),
    .sqx       (s3_sqx),
    .sqy       (s3_sqy),
    .sqr       (s3_sqr),
    .overlap_r (out_overlap)
  );

endmodule

// ===== src/spc_prep.sv =====
// ----------------------------------------------------------------------------
// spc_prep
// Stage 1: order the shapes by kind, settle the direct tests (point/point,
// rect/rect, point/rect, bad kind) and pick the operands of the distance test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_prep #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  spc_pkg::kind_t               first_kind,
  input  logic signed [COORD_BITS-1:0] first_p0,
  input  logic signed [COORD_BITS-1:0] first_p1,
  input  logic signed [COORD_BITS-1:0] first_p2,
  input  logic signed [COORD_BITS-1:0] first_p3,
  input  spc_pkg::kind_t               second_kind,
  input  logic signed [COORD_BITS-1:0] second_p0,
  input  logic signed [COORD_BITS-1:0] second_p1,
  input  logic signed [COORD_BITS-1:0] second_p2,
  input  logic signed [COORD_BITS-1:0] second_p3,
  output spc_pkg::spc_ctrl_t           ctrl_r,
  output logic signed [COORD_BITS-1:0] ux_r,
  output logic signed [COORD_BITS-1:0] vx_r,
  output logic signed [COORD_BITS-1:0] uy_r,
  output logic signed [COORD_BITS-1:0] vy_r,
  output logic signed [COORD_BITS-1:0] ra_r,
  output logic signed [COORD_BITS-1:0] rb_r
);
  import spc_pkg::*;

  kind_t                         ka, kb;
  logic signed [COORD_BITS-1:0]  a0, a1, a2, a3, b0, b1, b2, b3;
  logic signed [COORD_BITS-1:0]  cx, cy;
  logic                          swap, bad;
  spc_ctrl_t                     ctrl_nxt;
  logic signed [COORD_BITS-1:0]  ux_nxt, vx_nxt, uy_nxt, vy_nxt, ra_nxt, rb_nxt;

  assign swap = first_kind > second_kind;
  assign bad  = (first_kind == KIND_BAD) || (second_kind == KIND_BAD);

  assign ka = swap ? second_kind : first_kind;
  assign kb = swap ? first_kind  : second_kind;
  assign a0 = swap ? second_p0 : first_p0;
  assign a1 = swap ? second_p1 : first_p1;
  assign a2 = swap ? second_p2 : first_p2;
  assign a3 = swap ? second_p3 : first_p3;
  assign b0 = swap ? first_p0 : second_p0;
  assign b1 = swap ? first_p1 : second_p1;
  assign b2 = swap ? first_p2 : second_p2;
  assign b3 = swap ? first_p3 : second_p3;

  // clamp the circle centre onto the rectangle: low edge first, then high
  assign cx = (b0 < a0) ? a0 : ((b0 > a2) ? a2 : b0);
  assign cy = (b1 < a1) ? a1 : ((b1 > a3) ? a3 : b1);

  always_comb begin
    ctrl_nxt = '0;
    ux_nxt   = a0;
    vx_nxt   = b0;
    uy_nxt   = a1;
    vy_nxt   = b1;
    ra_nxt   = a2;
    rb_nxt   = b2;
    if (!bad) begin
      unique case ({ka, kb})
        {KIND_POINT, KIND_POINT}: begin
          ctrl_nxt.hit = (a0 == b0) && (a1 == b1);
        end
        {KIND_RECT, KIND_RECT}: begin
          ctrl_nxt.hit = (a0 < b2) && (a2 > b0) && (a1 < b3) && (a3 > b1);
        end
        {KIND_POINT, KIND_RECT}: begin
          ctrl_nxt.hit = (a0 > b0) && (a0 < b2) && (a1 > b1) && (a1 < b3);
        end
        {KIND_CIRCLE, KIND_CIRCLE}: begin
          ctrl_nxt.use_dist = 1'b1;
        end
        {KIND_POINT, KIND_CIRCLE}: begin
          ctrl_nxt.use_dist = 1'b1;
          ra_nxt            = '0;
        end
        {KIND_RECT, KIND_CIRCLE}: begin
          ctrl_nxt.use_dist = 1'b1;
          ux_nxt            = cx;
          uy_nxt            = cy;
          ra_nxt            = '0;
        end
        default: begin
          ctrl_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl_r <= ctrl_nxt;
      ux_r   <= ux_nxt;
      vx_r   <= vx_nxt;
      uy_r   <= uy_nxt;
      vy_r   <= vy_nxt;
      ra_r   <= ra_nxt;
      rb_r   <= rb_nxt;
    end
  end

endmodule

// ===== src/spc_diff.sv =====
// ----------------------------------------------------------------------------
// spc_diff
// Stage 2: form the axis offsets and the radius (sum) one bit wider than
// the coordinates so nothing wraps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_diff #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  spc_pkg::spc_ctrl_t           ctrl,
  input  logic signed [COORD_BITS-1:0] ux,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] uy,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic signed [COORD_BITS-1:0] ra,
  input  logic signed [COORD_BITS-1:0] rb,
  output spc_pkg::spc_ctrl_t           ctrl_r,
  output logic signed [COORD_BITS:0]   dx_r,
  output logic signed [COORD_BITS:0]   dy_r,
  output logic signed [COORD_BITS:0]   rad_r
);
  import spc_pkg::*;

  logic [COORD_BITS:0] dx_nxt, dy_nxt, rad_nxt;

  assign dx_nxt  = {ux[COORD_BITS-1], ux} - {vx[COORD_BITS-1], vx};
  assign dy_nxt  = {uy[COORD_BITS-1], uy} - {vy[COORD_BITS-1], vy};
  assign rad_nxt = {ra[COORD_BITS-1], ra} + {rb[COORD_BITS-1], rb};

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl_r <= ctrl;
      dx_r   <= $signed(dx_nxt);
      dy_r   <= $signed(dy_nxt);
      rad_r  <= $signed(rad_nxt);
    end
  end

endmodule

// ===== src/spc_square.sv =====
// ----------------------------------------------------------------------------
// spc_square
// Stage 3: square the two offsets and the radius, exact, one multiplier each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_square #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       load,
  input  spc_pkg::spc_ctrl_t         ctrl,
  input  logic signed [COORD_BITS:0] dx,
  input  logic signed [COORD_BITS:0] dy,
  input  logic signed [COORD_BITS:0] rad,
  output spc_pkg::spc_ctrl_t         ctrl_r,
  output logic [2*COORD_BITS:0]      sqx_r,
  output logic [2*COORD_BITS:0]      sqy_r,
  output logic [2*COORD_BITS:0]      sqr_r
);
  import spc_pkg::*;

  localparam int PW = 2*COORD_BITS+2;

  // squares never exceed 2^(2*COORD_BITS), so the top product bit is zero
  logic signed [2*COORD_BITS+1:0] px, py, pr;

  assign px = PW'(dx) * PW'(dx);
  assign py = PW'(dy) * PW'(dy);
  assign pr = PW'(rad) * PW'(rad);

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl_r <= ctrl;
      sqx_r  <= px[2*COORD_BITS:0];
      sqy_r  <= py[2*COORD_BITS:0];
      sqr_r  <= pr[2*COORD_BITS:0];
    end
  end

endmodule

// ===== src/spc_compare.sv =====
// ----------------------------------------------------------------------------
// spc_compare
// Stage 4: add the squared offsets, compare strictly against the squared
// radius and pick the final answer into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_compare #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  load,
  input  spc_pkg::spc_ctrl_t    ctrl,
  input  logic [2*COORD_BITS:0] sqx,
  input  logic [2*COORD_BITS:0] sqy,
  input  logic [2*COORD_BITS:0] sqr,
  output logic                  overlap_r
);
  import spc_pkg::*;

  logic [2*COORD_BITS+1:0] dist2;
  logic                    below;
  logic                    overlap_nxt;

  assign dist2       = {1'b0, sqx} + {1'b0, sqy};
  assign below       = dist2 < {1'b0, sqr};
  assign overlap_nxt = ctrl.use_dist ? below : ctrl.hit;

  always_ff @(posedge clk) begin
    if (load) begin
      overlap_r <= overlap_nxt;
    end
  end

endmodule

// ===== src/spc_checker.sv =====
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks for the shape pair collision test, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_overlap
);
  import spc_pkg::*;

  localparam int CNT_BITS = $clog2(PIPE_STAGES + 1);

  logic                in_xfer, out_xfer;
  logic [CNT_BITS-1:0] occ_r, occ_nxt;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    occ_nxt = occ_r;
    if (in_xfer && !out_xfer) occ_nxt = occ_r + 1'b1;
    if (!in_xfer && out_xfer) occ_nxt = occ_r - 1'b1;
  end

  // track items in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `SPC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_overlap), "held result changed")
  `SPC_ASSERT(a_stall_only_full, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled while output moves")
  `SPC_ASSERT(a_occupancy, clk, rst_n, (occ_r <= CNT_BITS'(PIPE_STAGES)) && (!out_valid || occ_r != '0), "items in flight out of range")
  `SPC_ASSERT_NR(a_reset_empty, clk, rst_n && $past(!rst_n) |-> !out_valid, "result valid right after reset")

endmodule

bind shape_pair_collision_test spc_checker u_spc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_overlap (out_overlap)
);

// ===== tb/shape_pair_collision_test_test.sv =====
// ----------------------------------------------------------------------------
// shape_pair_collision_test_test
// Self-checking bench for the shape pair collision pipeline: a queue-fed
// driver pushes shape pairs, an in-bench overlap predictor computes the
// expected flag per transfer, and a monitor compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shape_pair_collision_test_test;
  import spc_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int RANDOM_PAIRS_PER_PHASE = 163;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    kind_t  kind;
    coord_t p0;
    coord_t p1;
    coord_t p2;
    coord_t p3;
  } shape_t;

  typedef struct packed {
    shape_t first;
    shape_t second;
  } pair_t;

  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // --------------------------------------------------------------------------
  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_overlap;

  // Payload register; ports follow it so one NBA updates the whole pair
  pair_t drv_pair = '0;

  always #10 clk = ~clk;

  shape_pair_collision_test dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_first_kind (drv_pair.first.kind),
    .in_first_p0   (drv_pair.first.p0),
    .in_first_p1   (drv_pair.first.p1),
    .in_first_p2   (drv_pair.first.p2),
    .in_first_p3   (drv_pair.first.p3),
    .in_second_kind(drv_pair.second.kind),
    .in_second_p0  (drv_pair.second.p0),
    .in_second_p1  (drv_pair.second.p1),
    .in_second_p2  (drv_pair.second.p2),
    .in_second_p3  (drv_pair.second.p3),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_overlap   (out_overlap)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  pair_t pairs_to_send[$];   // stimulus waiting for the driver
  bit    overlap_due[$];     // predicted flags, oldest first
  int    idle_pct  = 0;      // chance per cycle that the sender holds off
  int    stall_pct = 0;      // chance per cycle that the receiver stalls
  int    mismatches = 0;

  // --------------------------------------------------------------------------
  // Overlap predictor
  // --------------------------------------------------------------------------
  // Strict squared-distance compare; all terms fit easily in 64 bits.
  function automatic bit within_radius(longint dx, longint dy, longint r);
    return dx * dx + dy * dy < r * r;
  endfunction

  function automatic bit predict_overlap(shape_t f, shape_t s);
    shape_t a, b;
    longint a0, a1, a2, a3, b0, b1, b2, b3, nx, ny;
    // An undefined kind on either side never collides
    if (f.kind == KIND_BAD || s.kind == KIND_BAD) return 1'b0;
    // Order the pair by kind so each combination has one test
    if (f.kind > s.kind) begin
      a = s;
      b = f;
    end else begin
      a = f;
      b = s;
    end
    a0 = longint'($signed(a.p0));
    a1 = longint'($signed(a.p1));
    a2 = longint'($signed(a.p2));
    a3 = longint'($signed(a.p3));
    b0 = longint'($signed(b.p0));
    b1 = longint'($signed(b.p1));
    b2 = longint'($signed(b.p2));
    b3 = longint'($signed(b.p3));
    case ({a.kind, b.kind})
      {KIND_POINT, KIND_POINT}:   return a0 == b0 && a1 == b1;
      {KIND_RECT, KIND_RECT}:     return a0 < b2 && a2 > b0 && a1 < b3 && a3 > b1;
      {KIND_CIRCLE, KIND_CIRCLE}: return within_radius(a0 - b0, a1 - b1, a2 + b2);
      {KIND_POINT, KIND_RECT}:    return a0 > b0 && a0 < b2 && a1 > b1 && a1 < b3;
      {KIND_POINT, KIND_CIRCLE}:  return within_radius(b0 - a0, b1 - a1, b2);
      default: begin
        // Rectangle against circle: clamp low edge first, then high edge
        nx = (b0 < a0) ? a0 : ((b0 > a2) ? a2 : b0);
        ny = (b1 < a1) ? a1 : ((b1 > a3) ? a3 : b1);
        return within_radius(nx - b0, ny - b1, b2);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic shape_t mk(kind_t k, longint c0, longint c1, longint c2,
                                longint c3);
    shape_t sh;
    sh.kind = k;
    sh.p0   = coord_t'(c0);
    sh.p1   = coord_t'(c1);
    sh.p2   = coord_t'(c2);
    sh.p3   = coord_t'(c3);
    return sh;
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  // Offset around a cluster center; grid mode lands on whole units so
  // touching edges and equal points come up often
  function automatic longint jitter(int span, bit grid);
    if (grid) return 256 * (longint'($urandom_range(0, 8)) - 4);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint extent(int span, bit grid);
    if (grid) return 256 * longint'($urandom_range(0, 4));
    return longint'($urandom_range(0, span));
  endfunction

  // Well-formed shape near (cx, cy), with the odd inverted rectangle or
  // negative radius mixed in
  function automatic shape_t near_shape(longint cx, longint cy, int span, bit grid);
    shape_t sh;
    longint x0, y0, w, h;
    sh.kind = kind_t'($urandom_range(0, 2));
    x0 = cx + jitter(span, grid);
    y0 = cy + jitter(span, grid);
    w  = extent(span, grid);
    h  = extent(span, grid);
    case (sh.kind)
      KIND_POINT:  sh = mk(KIND_POINT, x0, y0, any_coord(), any_coord());
      KIND_RECT: begin
        if ($urandom_range(0, 15) == 0) sh = mk(KIND_RECT, x0 + w, y0, x0, y0 + h);
        else if ($urandom_range(0, 15) == 0) sh = mk(KIND_RECT, x0, y0 + h, x0 + w, y0);
        else sh = mk(KIND_RECT, x0, y0, x0 + w, y0 + h);
      end
      default: begin
        if ($urandom_range(0, 15) == 0) w = -w;
        sh = mk(KIND_CIRCLE, x0, y0, w, any_coord());
      end
    endcase
    return sh;
  endfunction

  function automatic pair_t random_pair();
    pair_t  pr;
    int     pick, span;
    bit     grid;
    longint cx, cy;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      // Clustered pair: roughly even split of hits and misses
      grid = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 2))
        0:       span = 256;
        1:       span = 4096;
        default: span = 65536;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        // Hug the ends of the coordinate range, wrap included
        cx = $urandom_range(0, 1) ? longint'(C_MAX) : longint'(C_MIN);
        cy = $urandom_range(0, 1) ? longint'(C_MAX) : longint'(C_MIN);
      end else begin
        cx = longint'($urandom_range(0, 1 << (CW - 1))) - (1 << (CW - 2));
        cy = longint'($urandom_range(0, 1 << (CW - 1))) - (1 << (CW - 2));
      end
      pr.first  = near_shape(cx, cy, span, grid);
      pr.second = near_shape(cx, cy, span, grid);
    end else begin
      // Noise across the whole field range; kind three shows up here
      pr.first  = mk(kind_t'($urandom_range(0, pick < 95 ? 2 : 3)), any_coord(),
                     any_coord(), any_coord(), any_coord());
      pr.second = mk(kind_t'($urandom_range(0, pick < 95 ? 2 : 3)), any_coord(),
                     any_coord(), any_coord(), any_coord());
    end
    return pr;
  endfunction

  task automatic queue_pair(shape_t f, shape_t s);
    pair_t pr;
    pr.first  = f;
    pr.second = s;
    pairs_to_send.push_back(pr);
  endtask

  // Hold the stimulus until everything sent has come back
  task automatic wait_drained();
    while (pairs_to_send.size() != 0 || in_valid || overlap_due.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: hold a stalled pair, otherwise advance or idle at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict each pair at the edge on which its transfer happens
      if (in_valid && !in_stall)
        overlap_due.push_back(predict_overlap(drv_pair.first, drv_pair.second));
      if (!in_valid || !in_stall) begin
        if (pairs_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_pair <= pairs_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare of each result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (overlap_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result with nothing expected, overlap=%0b",
                     $realtime, out_overlap);
          mismatches++;
        end else begin
          want = overlap_due.pop_front();
          if (out_overlap !== want) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: overlap mismatch, expected %0b, got %0b",
                       $realtime, want, out_overlap);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed pairs, then four phases of random pairs
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Points: equal, one LSB apart, range corner with junk in unused fields
    queue_pair(mk(KIND_POINT, 0, 0, 5, 7), mk(KIND_POINT, 0, 0, -3, 9));
    queue_pair(mk(KIND_POINT, 256, 256, 0, 0), mk(KIND_POINT, 256, 257, 0, 0));
    queue_pair(mk(KIND_POINT, C_MIN, C_MIN, C_MAX, C_MAX),
               mk(KIND_POINT, C_MIN, C_MIN, C_MIN, C_MIN));
    // Rectangles: overlap, shared edge, full range, inverted
    queue_pair(mk(KIND_RECT, 0, 0, 512, 512), mk(KIND_RECT, 256, 256, 768, 768));
    queue_pair(mk(KIND_RECT, 0, 0, 512, 512), mk(KIND_RECT, 512, 0, 768, 512));
    queue_pair(mk(KIND_RECT, C_MIN, C_MIN, C_MAX, C_MAX),
               mk(KIND_RECT, C_MIN, C_MIN, C_MAX, C_MAX));
    queue_pair(mk(KIND_RECT, 512, 0, 0, 512), mk(KIND_RECT, 0, 0, 512, 512));
    // Point against rectangle: inside, on the edge with rectangle first
    queue_pair(mk(KIND_POINT, 100, 100, 0, 0), mk(KIND_RECT, 0, 0, 256, 256));
    queue_pair(mk(KIND_RECT, 0, 0, 256, 256), mk(KIND_POINT, 0, 100, 0, 0));
    // Circles: overlap, tangent, negative radii
    queue_pair(mk(KIND_CIRCLE, 0, 0, 300, 0), mk(KIND_CIRCLE, 512, 0, 300, 0));
    queue_pair(mk(KIND_CIRCLE, 0, 0, 256, 1), mk(KIND_CIRCLE, 512, 0, 256, 2));
    queue_pair(mk(KIND_CIRCLE, 0, 0, -256, 0), mk(KIND_CIRCLE, 500, 0, -300, 0));
    queue_pair(mk(KIND_CIRCLE, C_MIN, C_MIN, C_MAX, 0),
               mk(KIND_CIRCLE, C_MAX, C_MAX, C_MAX, 0));
    // Point against circle: inside, on the boundary, negative radius
    queue_pair(mk(KIND_POINT, 10, 10, 0, 0), mk(KIND_CIRCLE, 0, 0, 256, 0));
    queue_pair(mk(KIND_POINT, 768, 1024, 0, 0), mk(KIND_CIRCLE, 0, 0, 1280, 0));
    queue_pair(mk(KIND_CIRCLE, 0, 0, -256, 0), mk(KIND_POINT, 20, -20, 0, 0));
    // Rectangle against circle: center inside, corner just in and just out,
    // tangent edge, inverted rectangle, zero radius with circle first
    queue_pair(mk(KIND_RECT, 0, 0, 256, 256), mk(KIND_CIRCLE, 128, 128, 16, 0));
    queue_pair(mk(KIND_RECT, 0, 0, 256, 256), mk(KIND_CIRCLE, 512, 512, 363, 0));
    queue_pair(mk(KIND_RECT, 0, 0, 256, 256), mk(KIND_CIRCLE, 512, 512, 362, 0));
    queue_pair(mk(KIND_RECT, 0, 0, 256, 256), mk(KIND_CIRCLE, 512, 128, 256, 0));
    queue_pair(mk(KIND_RECT, 256, 256, 0, 0), mk(KIND_CIRCLE, 128, 128, 64, 0));
    queue_pair(mk(KIND_CIRCLE, 128, 128, 0, 0), mk(KIND_RECT, 0, 0, 256, 256));
    // Undefined kind on either side, then on both
    queue_pair(mk(KIND_BAD, 0, 0, 0, 0), mk(KIND_POINT, 0, 0, 0, 0));
    queue_pair(mk(KIND_RECT, 0, 0, 256, 256), mk(KIND_BAD, 0, 0, 256, 256));
    queue_pair(mk(KIND_BAD, C_MAX, C_MIN, C_MAX, C_MIN),
               mk(KIND_BAD, C_MIN, C_MAX, C_MIN, C_MAX));
    wait_drained();

    // Each phase ends with a full drain so the pipe also sees a cold start
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 73; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      for (int n = 0; n < RANDOM_PAIRS_PER_PHASE; n++)
        pairs_to_send.push_back(random_pair());
      wait_drained();
    end

    // Let the pipe run empty to catch any stray result
    idle_pct  = 0;
    stall_pct = 0;
    repeat (4 * PIPE_STAGES) @(posedge clk);
    if (overlap_due.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("shape_pair_collision_test_test passed");
    end else begin
      $display("shape_pair_collision_test_test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(200_000 * 20);
    $display("shape_pair_collision_test_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/spc_pkg.sv
src/spc_prep.sv
src/spc_diff.sv
src/spc_square.sv
src/spc_compare.sv
src/shape_pair_collision_test.sv
src/spc_checker.sv
tb/shape_pair_collision_test_test.sv
